// ===== hw/rtl/bsd_pkg.sv =====
// Shared constants and types for the descending insertion sorter.
package bsd_pkg;

	localparam int MAX_ELEMENTS = 32;
	localparam int VALUE_WIDTH  = 16;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

	// What one cell shows its neighbors.
	typedef struct packed {
		logic                          valid;
		logic                          ge;
		logic signed [VALUE_WIDTH-1:0] value;
	} cell_link_t;

	// Broadcast control to every cell of the row.
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/bsd_cell.sv =====
// One cell of the sorting row: holds one word and trades it with its neighbors.
module bsd_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bsd_pkg::cell_ctrl_t                    ctrl,
	input  logic signed [bsd_pkg::VALUE_WIDTH-1:0] x,
	input  bsd_pkg::cell_link_t                    left,
	input  bsd_pkg::cell_link_t                    right,
	output bsd_pkg::cell_link_t                    link
);
	import bsd_pkg::*;

	logic                          valid_q;
	logic signed [VALUE_WIDTH-1:0] value_q;
	logic                          ge;

	// A cell keeps its word when it is at least the incoming one; otherwise it
	// takes the new word if its left neighbor keeps, or the neighbor's word.
	assign ge = valid_q && (value_q >= x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right.valid;
		end else if (ctrl.ins) begin
			valid_q <= valid_q | left.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right.value;
		end else if (ctrl.ins && !ge) begin
			value_q <= left.ge ? x : left.value;
		end
	end

	assign link.valid = valid_q;
	assign link.ge    = ge;
	assign link.value = value_q;

endmodule

// ===== hw/rtl/bubble_sort_descending_unit.sv =====
// Top level: row of insertion cells, fill counter and drain sequencer.
// Each word is inserted as it arrives: one word per cycle while filling.
// A word with last_in starts the drain; in drain the first cell's word is registered as the first result.
// The row then shifts out one sorted word per cycle, n results for n stored words.
// busy is high for the whole drain; the next word is taken as the last result shows.
// Reset clears the fill count, the overflow mark and every cell's valid bit.
module bubble_sort_descending_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [bsd_pkg::VALUE_WIDTH-1:0] value,
	input  logic                                   last_in,
	output logic                                   strobe,
	output logic signed [bsd_pkg::VALUE_WIDTH-1:0] sorted_value,
	output logic                                   last_out,
	output logic                                   overflow
);
	import bsd_pkg::*;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic              dropped_q;
	logic              accept;
	logic              full;
	cell_ctrl_t        ctrl;
	cell_link_t        links [MAX_ELEMENTS];
	cell_link_t        head;
	cell_link_t        tail;

	assign busy   = (state_q == ST_DRAIN);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_ELEMENTS));

	assign ctrl.ins   = accept && !full;
	assign ctrl.shift = busy;

	// A virtual neighbor left of the first cell that always keeps its word,
	// and an empty one right of the last cell.
	assign head.valid = 1'b1;
	assign head.ge    = 1'b1;
	assign head.value = '0;
	assign tail.valid = 1'b0;
	assign tail.ge    = 1'b0;
	assign tail.value = '0;

	for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
		bsd_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.x     (value),
			.left  ((k == 0) ? head : links[(k == 0) ? 0 : k - 1]),
			.right ((k == MAX_ELEMENTS - 1) ? tail
			        : links[(k == MAX_ELEMENTS - 1) ? k : k + 1]),
			.link  (links[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			count_q   <= '0;
			dropped_q <= 1'b0;
			strobe    <= 1'b0;
			last_out  <= 1'b0;
			overflow  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_FILL: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last_in) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					strobe   <= 1'b1;
					last_out <= (count_q == CNT_W'(1));
					overflow <= dropped_q;
					count_q  <= count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						state_q   <= ST_FILL;
						dropped_q <= 1'b0;
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			sorted_value <= links[0].value;
		end
	end

endmodule

// ===== hw/rtl/bsd_checker.sv =====
// Port-level checks for the descending sorter, bound to its top level.
module bsd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_in,
	input logic strobe,
	input logic last_out
);

	// A word that closes a list starts the drain.
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_in |=> busy)
		else $error("drain did not start after a closing word");

	// Results only follow drain cycles.
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result shown outside a drain");

	// The drain ends exactly with the final result of the run.
	a_end_marked: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last_out)
		else $error("drain ended without a final result");

	a_more_to_come: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_out |-> busy)
		else $error("drain stopped before the final result");

	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_out |-> !busy)
		else $error("still busy on the final result");

endmodule

bind bubble_sort_descending_unit bsd_checker u_bsd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.last_in (last_in),
	.strobe  (strobe),
	.last_out(last_out)
);
